### rtl/plpr_pkg.sv
`default_nettype none

package plpr_pkg;

	// printer RAM address width (fill counter wraps at 2**RAM_ADDR_BITS)
	localparam int RAM_ADDR_BITS = 13;

	// width of the RAM address and length fields on the result word
	localparam int FIELD_BITS = 13;

	// protocol bytes
	localparam logic [7:0] SYNC_BYTE0 = 8'h88;
	localparam logic [7:0] SYNC_BYTE1 = 8'h33;
	localparam logic [7:0] ALIVE_REPLY = 8'h81;

	// command codes
	localparam logic [7:0] CMD_INIT  = 8'h01;
	localparam logic [7:0] CMD_PRINT = 8'h02;
	localparam logic [7:0] CMD_DATA  = 8'h04;

	// RAM fill level that reports "full" in the status byte
	localparam logic [31:0] FULL_LEVEL = 32'h0000_0280;

	// status byte bits
	localparam int ST_SUM_ERR = 0;
	localparam int ST_PRINT   = 2;
	localparam int ST_FULL    = 3;

	// receive phase
	typedef enum logic [2:0] {
		PH_SYNC   = 3'd0,
		PH_CMD    = 3'd1,
		PH_COMP   = 3'd2,
		PH_LEN    = 3'd3,
		PH_DATA   = 3'd4,
		PH_SUM    = 3'd5,
		PH_ALIVE  = 3'd6,
		PH_STATUS = 3'd7
	} phase_t;

	// one result word
	typedef struct packed {
		logic [FIELD_BITS-1:0] print_length;
		logic [7:0]            print_palette;
		logic                  print_start;
		logic                  ram_clear;
		logic [7:0]            ram_data;
		logic [FIELD_BITS-1:0] ram_addr;
		logic                  ram_write;
		logic [7:0]            tx_byte;
	} result_t;

	// fill counter onto a result field, truncated or zero-extended
	function automatic logic [FIELD_BITS-1:0] fill_to_field(
		input logic [RAM_ADDR_BITS-1:0] f);
		logic [31:0] w;
		w = 32'(f);
		return w[FIELD_BITS-1:0];
	endfunction

endpackage

`default_nettype wire

### rtl/plpr_core.sv
`default_nettype none

module plpr_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic [7:0]        rx_byte,
	output plpr_pkg::result_t      res
);

	plpr_pkg::phase_t phase_q, phase_d;
	logic [15:0] step_count_q, step_count_d;
	logic [7:0]  command_q, command_d;
	logic [15:0] data_length_q, data_length_d;
	logic [15:0] running_sum_q, running_sum_d;
	logic [15:0] received_sum_q, received_sum_d;
	logic        sum_ok_q, sum_ok_d;
	logic        print_req_q, print_req_d;
	logic [plpr_pkg::RAM_ADDR_BITS-1:0] fill_q, fill_d;
	logic [7:0]  palette_q, palette_d;
	logic [7:0]  reply_q, reply_d;

	logic [15:0] sum_plus;
	logic [15:0] step_plus;
	logic [15:0] rsum_full;
	logic [7:0]  status;

	assign sum_plus  = running_sum_q + 16'(rx_byte);
	assign step_plus = step_count_q + 16'd1;
	assign rsum_full = {rx_byte, received_sum_q[7:0]};

	// status byte as reported after a non-init packet
	always_comb begin
		status = '0;
		status[plpr_pkg::ST_SUM_ERR] = !sum_ok_q;
		status[plpr_pkg::ST_PRINT]   = print_req_q;
		status[plpr_pkg::ST_FULL]    = 32'(fill_q) >= plpr_pkg::FULL_LEVEL;
	end

	// next state and result for one received word
	always_comb begin
		phase_d        = phase_q;
		step_count_d   = step_count_q;
		command_d      = command_q;
		data_length_d  = data_length_q;
		running_sum_d  = running_sum_q;
		received_sum_d = received_sum_q;
		sum_ok_d       = sum_ok_q;
		print_req_d    = print_req_q;
		fill_d         = fill_q;
		palette_d      = palette_q;
		reply_d        = reply_q;
		res            = '0;

		unique case (phase_q)
			plpr_pkg::PH_SYNC: begin
				if (rx_byte == plpr_pkg::SYNC_BYTE0) begin
					step_count_d = 16'd1;
					reply_d      = '0;
				end else if (rx_byte == plpr_pkg::SYNC_BYTE1 && step_count_q == 16'd1) begin
					step_count_d = '0;
					phase_d      = plpr_pkg::PH_CMD;
					reply_d      = '0;
				end
			end
			plpr_pkg::PH_CMD: begin
				running_sum_d = sum_plus;
				command_d     = rx_byte;
				reply_d       = '0;
				phase_d       = plpr_pkg::PH_COMP;
			end
			plpr_pkg::PH_COMP: begin
				running_sum_d = sum_plus;
				reply_d       = '0;
				phase_d       = plpr_pkg::PH_LEN;
			end
			plpr_pkg::PH_LEN: begin
				running_sum_d = sum_plus;
				reply_d       = '0;
				if (step_count_q == '0) begin
					data_length_d = {8'h00, rx_byte};
					step_count_d  = 16'd1;
				end else begin
					data_length_d = {rx_byte, data_length_q[7:0]};
					phase_d = ({rx_byte, data_length_q[7:0]} != '0) ?
						plpr_pkg::PH_DATA : plpr_pkg::PH_SUM;
					step_count_d = '0;
					if (command_q == plpr_pkg::CMD_INIT) begin
						res.ram_clear = 1'b1;
						fill_d        = '0;
						print_req_d   = 1'b0;
					end
				end
			end
			plpr_pkg::PH_DATA: begin
				running_sum_d = sum_plus;
				reply_d       = '0;
				if (command_q == plpr_pkg::CMD_PRINT) begin
					if (step_count_q == 16'd2)
						palette_d = rx_byte;
				end else if (command_q == plpr_pkg::CMD_DATA) begin
					res.ram_write = 1'b1;
					res.ram_addr  = plpr_pkg::fill_to_field(fill_q);
					res.ram_data  = rx_byte;
					fill_d        = fill_q + {{(plpr_pkg::RAM_ADDR_BITS-1){1'b0}}, 1'b1};
				end
				step_count_d = step_plus;
				// last data word; a palette captured on this word goes out with it
				if (step_plus == data_length_q) begin
					phase_d      = plpr_pkg::PH_SUM;
					step_count_d = '0;
					if (command_q == plpr_pkg::CMD_PRINT) begin
						print_req_d       = 1'b1;
						res.print_start   = 1'b1;
						res.print_palette = palette_d;
						res.print_length  = plpr_pkg::fill_to_field(fill_q);
						fill_d            = '0;
					end
				end
			end
			plpr_pkg::PH_SUM: begin
				if (step_count_q == '0) begin
					received_sum_d = {8'h00, rx_byte};
					step_count_d   = 16'd1;
					reply_d        = '0;
				end else begin
					received_sum_d = rsum_full;
					sum_ok_d       = rsum_full == running_sum_q;
					running_sum_d  = '0;
					phase_d        = plpr_pkg::PH_ALIVE;
					step_count_d   = '0;
					reply_d        = plpr_pkg::ALIVE_REPLY;
				end
			end
			plpr_pkg::PH_ALIVE: begin
				phase_d = (rx_byte == '0) ? plpr_pkg::PH_STATUS : plpr_pkg::PH_SYNC;
				reply_d = plpr_pkg::ALIVE_REPLY;
			end
			plpr_pkg::PH_STATUS: begin
				reply_d = (command_q != plpr_pkg::CMD_INIT) ? status : 8'h00;
				phase_d = plpr_pkg::PH_SYNC;
			end
			default: begin
				phase_d = plpr_pkg::PH_SYNC;
			end
		endcase

		res.tx_byte = reply_d;
	end

	// protocol state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= plpr_pkg::PH_SYNC;
			step_count_q   <= '0;
			command_q      <= '0;
			data_length_q  <= '0;
			running_sum_q  <= '0;
			received_sum_q <= '0;
			sum_ok_q       <= 1'b0;
			print_req_q    <= 1'b0;
			fill_q         <= '0;
			palette_q      <= '0;
			reply_q        <= '0;
		end else if (step) begin
			phase_q        <= phase_d;
			step_count_q   <= step_count_d;
			command_q      <= command_d;
			data_length_q  <= data_length_d;
			running_sum_q  <= running_sum_d;
			received_sum_q <= received_sum_d;
			sum_ok_q       <= sum_ok_d;
			print_req_q    <= print_req_d;
			fill_q         <= fill_d;
			palette_q      <= palette_d;
			reply_q        <= reply_d;
		end
	end

`ifndef SYNTHESIS
	// a data-phase word never leaves the step counter past the length
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == plpr_pkg::PH_DATA) |-> (step_count_q < data_length_q))
		else $error("data step count ran past length");

	// two-byte fields only ever see step count 0 or 1
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == plpr_pkg::PH_LEN || phase_q == plpr_pkg::PH_SUM) |->
		(step_count_q <= 16'd1))
		else $error("length/checksum step count out of range");

	// sum restarts after every checksum
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == plpr_pkg::PH_ALIVE) |-> (running_sum_q == '0))
		else $error("running sum not cleared after checksum");
`endif

endmodule

`default_nettype wire

### rtl/printer_link_packet_receiver_top.sv
// Printer-side serial link packet receiver.
// Slave stream (s_axis_*): one received serial byte per word, tdata[7:0].
// Master stream (m_axis_*): one result word per input word, carrying the
// reply byte for the exchange, a printer RAM write, an init RAM clear and a
// print start with palette and length.
// Each accepted word is decoded in the cycle it is accepted and its result
// lands in the output register, so m_axis_tvalid rises in the cycle after
// input accept. Throughput is one word per cycle; the only limit is the
// single output register, which accepts a new word whenever it is empty or
// being emptied in the same cycle.
// If the downstream side stalls, the result holds in the output register and
// s_axis_tready drops until it is taken; no word is lost or repeated.
// Reset (arst_n low) returns the receiver to sync hunt with all counters,
// sums, flags, palette and reply cleared, and empties the output register.
`default_nettype none

module printer_link_packet_receiver_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// tx_byte[7:0], ram_write[8], ram_addr[21:9], ram_data[29:22],
	// ram_clear[30], print_start[31], print_palette[39:32],
	// print_length[52:40], zero[55:53]
	output logic [55:0]      m_axis_tdata
);

	plpr_pkg::result_t res;
	plpr_pkg::result_t result_s1;
	logic              valid_q;
	logic              accept;

	assign s_axis_tready = !valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	plpr_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (accept),
		.rx_byte (s_axis_tdata),
		.res     (res)
	);

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			valid_q <= s_axis_tvalid;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (accept) begin
			result_s1 <= res;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {3'b000, result_s1};

`ifndef SYNTHESIS
	// RAM fields are zero unless a write is flagged
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !result_s1.ram_write) |->
		(result_s1.ram_addr == '0 && result_s1.ram_data == '0))
		else $error("RAM fields set without write");

	// print fields are zero unless print starts
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !result_s1.print_start) |->
		(result_s1.print_palette == '0 && result_s1.print_length == '0))
		else $error("print fields set without print start");

	// a word is a RAM write, a clear or a print start, never two of them
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> $onehot0({result_s1.ram_write, result_s1.ram_clear,
		result_s1.print_start}))
		else $error("conflicting RAM/print events in one word");
`endif

endmodule

`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

	localparam bit TYPED = 1'b1;
	localparam bit FREE  = 1'b0;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;   // rx_byte[7:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// tx_byte[7:0], ram_write[8], ram_addr[21:9], ram_data[29:22], ram_clear[30],
	// print_start[31], print_palette[39:32], print_length[52:40], zero[55:53]
	logic [55:0] m_axis_tdata;

	printer_link_packet_receiver_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// cycle count; both sides run without idling inside the calm window
	int unsigned cyc = 0;
	always @(posedge clk) cyc <= cyc + 1;
	wire calm = (cyc >= 1500) && (cyc < 2300);

	// opening sequence: {fixed reply?, reply byte, rx byte}
	logic [16:0] opening [25] = '{
		{TYPED, 8'h00, plpr_pkg::SYNC_BYTE1},     // second sync byte while not armed
		{TYPED, 8'h00, plpr_pkg::SYNC_BYTE0},
		{TYPED, 8'h00, 8'h5A},                    // stray byte keeps the sync armed
		{TYPED, 8'h00, plpr_pkg::SYNC_BYTE1},
		{FREE,  8'h00, plpr_pkg::CMD_DATA},
		{FREE,  8'h00, 8'h00},
		{FREE,  8'h00, 8'h01},                    // length 1
		{FREE,  8'h00, 8'h00},
		{FREE,  8'h00, 8'hFF},                    // stored at address 0
		{TYPED, 8'h00, 8'h04},                    // checksum 0x0104, correct
		{TYPED, plpr_pkg::ALIVE_REPLY, 8'h01},
		{TYPED, plpr_pkg::ALIVE_REPLY, 8'h00},
		{TYPED, 8'h00, 8'hFF},                    // status: all clear
		{FREE,  8'h00, plpr_pkg::SYNC_BYTE0},
		{FREE,  8'h00, plpr_pkg::SYNC_BYTE1},
		{FREE,  8'h00, plpr_pkg::CMD_PRINT},
		{FREE,  8'h00, 8'hFF},
		{FREE,  8'h00, 8'h02},                    // two data bytes: palette not captured
		{FREE,  8'h00, 8'h00},
		{FREE,  8'h00, 8'hAA},
		{FREE,  8'h00, 8'h55},                    // print starts here
		{TYPED, 8'h00, 8'h00},                    // wrong checksum
		{TYPED, plpr_pkg::ALIVE_REPLY, 8'h00},
		{TYPED, plpr_pkg::ALIVE_REPLY, 8'hFF},    // nonzero alive skips status
		{TYPED, plpr_pkg::ALIVE_REPLY, plpr_pkg::SYNC_BYTE1} // unarmed: reply repeats
	};

	logic [16:0]       feed [$];
	plpr_pkg::result_t replies_due [$];
	int unsigned       errors = 0;

	// receiver model state
	plpr_pkg::phase_t                   stage = plpr_pkg::PH_SYNC;
	logic [15:0]                        step = '0;
	logic [7:0]                         cmd = '0;
	logic [15:0]                        data_len = '0;
	logic [15:0]                        run_sum = '0;
	logic [15:0]                        got_sum = '0;
	logic                               sum_good = 1'b0;
	logic                               print_req = 1'b0;
	logic [plpr_pkg::RAM_ADDR_BITS-1:0] fill = '0;
	logic [7:0]                         palette = '0;
	logic [7:0]                         reply = '0;

	task automatic advance_receiver(input logic [7:0] b, output plpr_pkg::result_t r);
		r = '0;
		case (stage)
			plpr_pkg::PH_SYNC: begin
				if (b == plpr_pkg::SYNC_BYTE0) begin
					step = 16'd1;
					reply = 8'h00;
				end else if (b == plpr_pkg::SYNC_BYTE1 && step == 16'd1) begin
					step = 16'd0;
					stage = plpr_pkg::PH_CMD;
					reply = 8'h00;
				end
			end
			plpr_pkg::PH_CMD: begin
				run_sum += 16'(b);
				cmd = b;
				reply = 8'h00;
				stage = plpr_pkg::PH_COMP;
			end
			plpr_pkg::PH_COMP: begin
				run_sum += 16'(b);
				reply = 8'h00;
				stage = plpr_pkg::PH_LEN;
			end
			plpr_pkg::PH_LEN: begin
				run_sum += 16'(b);
				reply = 8'h00;
				if (step == 16'd0) begin
					data_len = 16'(b);
					step = 16'd1;
				end else begin
					data_len = {b, data_len[7:0]};
					step = 16'd0;
					if (data_len != 16'd0)
						stage = plpr_pkg::PH_DATA;
					else
						stage = plpr_pkg::PH_SUM;
					if (cmd == plpr_pkg::CMD_INIT) begin
						r.ram_clear = 1'b1;
						fill = '0;
						print_req = 1'b0;
					end
				end
			end
			plpr_pkg::PH_DATA: begin
				run_sum += 16'(b);
				if (cmd == plpr_pkg::CMD_PRINT) begin
					if (step == 16'd2)
						palette = b;
				end else if (cmd == plpr_pkg::CMD_DATA) begin
					r.ram_write = 1'b1;
					r.ram_addr = plpr_pkg::fill_to_field(fill);
					r.ram_data = b;
					fill += 1'b1;
				end
				step += 16'd1;
				if (step == data_len) begin
					stage = plpr_pkg::PH_SUM;
					step = 16'd0;
					if (cmd == plpr_pkg::CMD_PRINT) begin
						print_req = 1'b1;
						r.print_start = 1'b1;
						r.print_palette = palette;
						r.print_length = plpr_pkg::fill_to_field(fill);
						fill = '0;
					end
				end
				reply = 8'h00;
			end
			plpr_pkg::PH_SUM: begin
				if (step == 16'd0) begin
					got_sum = 16'(b);
					step = 16'd1;
					reply = 8'h00;
				end else begin
					got_sum = {b, got_sum[7:0]};
					sum_good = (got_sum == run_sum);
					run_sum = '0;
					stage = plpr_pkg::PH_ALIVE;
					step = 16'd0;
					reply = plpr_pkg::ALIVE_REPLY;
				end
			end
			plpr_pkg::PH_ALIVE: begin
				if (b == 8'h00)
					stage = plpr_pkg::PH_STATUS;
				else
					stage = plpr_pkg::PH_SYNC;
				reply = plpr_pkg::ALIVE_REPLY;
			end
			default: begin
				reply = 8'h00;
				if (cmd != plpr_pkg::CMD_INIT) begin
					reply[plpr_pkg::ST_SUM_ERR] = !sum_good;
					reply[plpr_pkg::ST_PRINT] = print_req;
					reply[plpr_pkg::ST_FULL] = (32'(fill) >= plpr_pkg::FULL_LEVEL);
				end
				stage = plpr_pkg::PH_SYNC;
			end
		endcase
		r.tx_byte = reply;
	endtask

	function automatic void put(input logic [7:0] b);
		feed.insert(feed.size(), {FREE, 8'h00, b});
	endfunction

	// one packet with random content; some bad checksums, some nonzero alive
	task automatic queue_packet(input logic [7:0] c, input logic [15:0] len);
		logic [15:0] sum;
		logic [7:0]  b;
		logic [7:0]  alive;
		b = 8'($urandom);
		sum = 16'(c) + 16'(b) + 16'(len[7:0]) + 16'(len[15:8]);
		put(plpr_pkg::SYNC_BYTE0);
		put(plpr_pkg::SYNC_BYTE1);
		put(c);
		put(b);
		put(len[7:0]);
		put(len[15:8]);
		for (int i = 0; i < int'(len); i++) begin
			b = 8'($urandom);
			put(b);
			sum += 16'(b);
		end
		if ($urandom_range(7) == 0)
			sum ^= 16'($urandom_range(1, 65535));
		put(sum[7:0]);
		put(sum[15:8]);
		alive = ($urandom_range(7) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
		put(alive);
		if (alive == 8'h00)
			put(8'($urandom));
	endtask

	function automatic logic [15:0] pick_length(input logic [7:0] c);
		int unsigned r;
		r = $urandom_range(31);
		if (c == plpr_pkg::CMD_INIT && r < 24)
			return 16'd0;
		if (r == 0)
			return 16'($urandom_range(600, 700));
		if (r == 1)
			return 16'($urandom_range(256, 280));
		if (r < 4)
			return 16'd0;
		if (r < 8)
			return 16'($urandom_range(13, 60));
		return 16'($urandom_range(1, 12));
	endfunction

	task automatic check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			errors++;
		end
	endtask

	// result checking
	plpr_pkg::result_t seen, due;
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (replies_due.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
			end else begin
				due = replies_due.pop_front();
				seen = plpr_pkg::result_t'(m_axis_tdata[$bits(plpr_pkg::result_t)-1:0]);
				check_field("tx_byte", due.tx_byte, seen.tx_byte);
				check_field("ram_write", due.ram_write, seen.ram_write);
				check_field("ram_addr", due.ram_addr, seen.ram_addr);
				check_field("ram_data", due.ram_data, seen.ram_data);
				check_field("ram_clear", due.ram_clear, seen.ram_clear);
				check_field("print_start", due.print_start, seen.print_start);
				check_field("print_palette", due.print_palette, seen.print_palette);
				check_field("print_length", due.print_length, seen.print_length);
				check_field("pad", 0, m_axis_tdata[55:$bits(plpr_pkg::result_t)]);
			end
		end
	end

	// downstream side, with one long hold-off to back the block up
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (cyc == 600) begin
				m_axis_tready <= 1'b0;
				repeat (60) @(posedge clk);
			end
			m_axis_tready <= calm || ($urandom_range(99) >= 20);
		end
	end

	// stimulus, reset, feeding and end of run
	int unsigned       fed = 0;
	plpr_pkg::result_t next_due;
	initial begin
		for (int i = 0; i < 25; i++)
			feed.insert(feed.size(), opening[i]);
		while (feed.size() < 1930) begin
			if ($urandom_range(7) == 0)
				repeat ($urandom_range(1, 4)) put(8'($urandom));
			case ($urandom_range(15))
				0:             queue_packet(plpr_pkg::CMD_INIT, pick_length(plpr_pkg::CMD_INIT));
				1, 2, 3, 4:    queue_packet(plpr_pkg::CMD_PRINT, pick_length(plpr_pkg::CMD_PRINT));
				13:            queue_packet(8'h0F, pick_length(8'h0F));
				14, 15: begin
					next_due.tx_byte = 8'($urandom);
					queue_packet(next_due.tx_byte, pick_length(next_due.tx_byte));
				end
				default:       queue_packet(plpr_pkg::CMD_DATA, pick_length(plpr_pkg::CMD_DATA));
			endcase
		end
		// a print whose palette byte is also its last data byte
		queue_packet(plpr_pkg::CMD_PRINT, 16'd3);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		wait (arst_n === 1'b1);

		while (fed < feed.size()) begin
			@(posedge clk);
			if (s_axis_tvalid && s_axis_tready) begin
				advance_receiver(s_axis_tdata, next_due);
				if (feed[fed][16])
					next_due.tx_byte = feed[fed][15:8];
				replies_due.insert(replies_due.size(), next_due);
				fed++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (fed < feed.size() && (calm || $urandom_range(99) >= 20)) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= feed[fed][7:0];
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end

		while (replies_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// run limit
	initial begin
		#400000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
